// ===== hdl/ssdg_pkg.sv =====
`default_nettype none

package ssdg_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BASE_MV      = 2'd0,
      CSR_AMPLITUDE_MV = 2'd1,
      CSR_PERIOD_MS    = 2'd2
   } csr_index_type;

   localparam logic [11:0] BASE_MV_RESET      = 12'd1650;
   localparam logic [11:0] AMPLITUDE_MV_RESET = 12'd0;
   localparam logic [15:0] PERIOD_MS_RESET    = 16'd1000;

   // code = mv * 4095 / 3300 = mv * 273 / 220, done as a multiply by a
   // rounded-up reciprocal that is exact for every mv below full scale.
   localparam logic [13:0] MV_FULL_SCALE = 14'd3300;
   localparam logic [11:0] CODE_MAX      = 12'd4095;
   localparam logic [20:0] CODE_RECIP    = 21'd1301188;
   localparam int          CODE_SHIFT    = 20;

   typedef enum logic [1:0] {
      LEVEL_BASE,
      LEVEL_HIGH,
      LEVEL_LOW
   } level_sel_type;

   typedef struct packed {
      logic [31:0] now_ms;
      logic        sync_level;
   } req_type;

   typedef struct packed {
      logic [11:0] dac_code;
      logic        dac_written;
      logic        sync_out_level;
      logic        led_level;
   } rsp_type;

   function automatic logic deadline_expired(logic [31:0] now, logic [31:0] deadline);
      logic [31:0] diff;
      diff = now - deadline;
      return !diff[31];
   endfunction

endpackage

`default_nettype wire

// ===== hdl/synced_square_wave_dac_gen.sv =====
`default_nettype none

// Square-wave DAC level generator with external sync. Each request beat is one
// poll (time in ms and the sync input level) and yields exactly one response
// beat with the DAC code, a written flag, the sync output and the LED. One poll
// is taken every cycle unless the response side stalls; a response passes through the
// input register and then the result register, with the state update and the
// millivolt to code conversion between them. Configuration must be written through
// the csr port only while no poll is in flight; the block does not enforce this.
module synced_square_wave_dac_gen #(
   parameter int unsigned SYNC_HOLD_MS = 10000
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  ssdg_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output ssdg_pkg::rsp_type                  rsp_data,
   input  logic                               csr_wr_en,
   input  logic [ssdg_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ssdg_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import ssdg_pkg::*;

   logic [11:0] base_mv_ff;
   logic [11:0] amplitude_mv_ff;
   logic [15:0] period_ms_ff;

   logic        in_valid_ff;
   req_type     in_data_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff;
   rsp_type     rsp_data_in;

   logic        prev_sync_ff,     prev_sync_in;
   logic        sync_active_ff,   sync_active_in;
   logic [31:0] sync_deadline_ff, sync_deadline_in;
   logic [31:0] half_deadline_ff, half_deadline_in;
   logic        phase_ff,         phase_in;
   logic [11:0] dac_value_ff,     dac_value_in;
   logic        sync_out_ff,      sync_out_in;
   logic        led_ff,           led_in;

   logic          move;
   logic          accept;
   logic          rising;
   logic          falling;
   logic          written;
   level_sel_type level_sel;
   logic signed [13:0] mv;
   logic [11:0]   conv_code;

   assign move      = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !move;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_mv_ff      <= BASE_MV_RESET;
         amplitude_mv_ff <= AMPLITUDE_MV_RESET;
         period_ms_ff    <= PERIOD_MS_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_BASE_MV:      base_mv_ff      <= csr_wdata[11:0];
            CSR_AMPLITUDE_MV: amplitude_mv_ff <= csr_wdata[11:0];
            CSR_PERIOD_MS:    period_ms_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign rising  = in_data_ff.sync_level && !prev_sync_ff;
   assign falling = !in_data_ff.sync_level && prev_sync_ff;

   always_comb begin
      prev_sync_in     = in_data_ff.sync_level;
      sync_active_in   = sync_active_ff;
      sync_deadline_in = sync_deadline_ff;
      half_deadline_in = half_deadline_ff;
      phase_in         = phase_ff;
      sync_out_in      = sync_out_ff;
      led_in           = led_ff;
      written          = 1'b0;
      level_sel        = LEVEL_BASE;

      if (rising) begin
         sync_active_in   = 1'b1;
         sync_deadline_in = in_data_ff.now_ms + 32'(SYNC_HOLD_MS);
         level_sel        = LEVEL_HIGH;
         led_in           = 1'b1;
         written          = 1'b1;
      end else if (sync_active_ff) begin
         if (falling) begin
            level_sel = LEVEL_LOW;
            led_in    = 1'b0;
            written   = 1'b1;
         end
         if (deadline_expired(in_data_ff.now_ms, sync_deadline_ff)) begin
            sync_active_in = 1'b0;
         end
      end else if (amplitude_mv_ff == 12'd0) begin
         half_deadline_in = in_data_ff.now_ms;
         phase_in         = 1'b0;
         level_sel        = LEVEL_BASE;
         written          = 1'b1;
      end else if (deadline_expired(in_data_ff.now_ms, half_deadline_ff)) begin
         half_deadline_in = in_data_ff.now_ms + {17'd0, period_ms_ff[15:1]};
         level_sel        = phase_ff ? LEVEL_LOW : LEVEL_HIGH;
         written          = 1'b1;
      end

      if (written && level_sel == LEVEL_HIGH) begin
         sync_out_in = 1'b1;
         phase_in    = 1'b1;
      end else if (written && level_sel == LEVEL_LOW) begin
         sync_out_in = 1'b0;
         phase_in    = 1'b0;
      end

      case (level_sel)
         LEVEL_HIGH: mv = $signed({2'b00, base_mv_ff}) + $signed({2'b00, amplitude_mv_ff});
         LEVEL_LOW:  mv = $signed({2'b00, base_mv_ff}) - $signed({2'b00, amplitude_mv_ff});
         default:    mv = $signed({2'b00, base_mv_ff});
      endcase

      dac_value_in = written ? conv_code : dac_value_ff;

      rsp_data_in.dac_code       = dac_value_in;
      rsp_data_in.dac_written    = written;
      rsp_data_in.sync_out_level = sync_out_in;
      rsp_data_in.led_level      = led_in;
   end

   ssdg_mv_to_code u_mv_to_code (
      .mv   (mv),
      .code (conv_code)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         prev_sync_ff     <= 1'b0;
         sync_active_ff   <= 1'b0;
         sync_deadline_ff <= 32'd0;
         half_deadline_ff <= 32'd0;
         phase_ff         <= 1'b0;
         dac_value_ff     <= 12'd0;
         sync_out_ff      <= 1'b0;
         led_ff           <= 1'b0;
      end else begin
         if (accept) begin
            in_valid_ff <= 1'b1;
         end else if (move) begin
            in_valid_ff <= 1'b0;
         end
         rsp_valid_ff <= move || (rsp_valid_ff && rsp_stall);
         if (move) begin
            prev_sync_ff     <= prev_sync_in;
            sync_active_ff   <= sync_active_in;
            sync_deadline_ff <= sync_deadline_in;
            half_deadline_ff <= half_deadline_in;
            phase_ff         <= phase_in;
            dac_value_ff     <= dac_value_in;
            sync_out_ff      <= sync_out_in;
            led_ff           <= led_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
      if (move) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // A poll is refused only while the input register holds a beat that cannot move on.
   assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> !req_stall)
      else $error("request stalled while the input register is empty");

   // A rising sync edge lights the LED, drives the high level and enters sync mode.
   assert property (@(posedge clock) disable iff (reset)
      (move && rising) |=> (led_ff && sync_out_ff && sync_active_ff && phase_ff))
      else $error("rising sync edge did not force the high level");

   // The DAC code only changes on a poll that writes it.
   assert property (@(posedge clock) disable iff (reset)
      (!move || !written) |=> $stable(dac_value_ff))
      else $error("DAC code changed without a write");

   // The reported code always matches the held DAC state.
   assert property (@(posedge clock) disable iff (reset)
      move |=> (rsp_data_ff.dac_code == dac_value_ff && rsp_data_ff.led_level == led_ff))
      else $error("response does not match the updated state");

endmodule

`default_nettype wire

// ===== hdl/ssdg_mv_to_code.sv =====
`default_nettype none

module ssdg_mv_to_code (
   input  logic signed [13:0] mv,
   output logic        [11:0] code
);
   import ssdg_pkg::*;

   logic [32:0] product;

   assign product = 33'(mv[11:0]) * 33'(CODE_RECIP);

   always_comb begin
      if (mv < 0) begin
         code = 12'd0;
      end else if (mv >= $signed(MV_FULL_SCALE)) begin
         code = CODE_MAX;
      end else begin
         code = product[CODE_SHIFT +: 12];
      end
   end

endmodule

`default_nettype wire
